### rtl/cld_pkg.sv
// Shared constants, datapath action codes and controller/datapath interface types.
`timescale 1ns / 1ps

package cld_pkg;

    localparam int MAX_ROWS        = 1024;
    localparam int ROW_W           = $clog2(MAX_ROWS);
    localparam int LINK_W          = $clog2(MAX_ROWS + 1);
    localparam int DEPTH_W         = $clog2(MAX_ROWS + 1);
    localparam int FIELD_ROW_W     = 10;
    localparam int COUNT_W         = 11;
    localparam int CFG_DATA_W      = 11;
    localparam int CFG_INDEX_W     = 1;
    localparam int RESET_ROW_COUNT = 1024;
    localparam int RESET_N         = (RESET_ROW_COUNT > MAX_ROWS) ? MAX_ROWS : RESET_ROW_COUNT;

    localparam logic [LINK_W-1:0] NO_ROW = LINK_W'(MAX_ROWS);

    // operation codes
    localparam logic [2:0] OP_UP     = 3'd0;
    localparam logic [2:0] OP_DOWN   = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_UNDO   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;
    localparam logic [2:0] OP_REINIT = 3'd5;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_END   = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_ROW = 1'd1;

    // datapath actions
    localparam logic [3:0] ACT_NONE        = 4'd0;
    localparam logic [3:0] ACT_CAPTURE     = 4'd1;
    localparam logic [3:0] ACT_SWEEP_INIT  = 4'd2;
    localparam logic [3:0] ACT_SWEEP       = 4'd3;
    localparam logic [3:0] ACT_MOVE_READ   = 4'd4;
    localparam logic [3:0] ACT_MOVE_STEP   = 4'd5;
    localparam logic [3:0] ACT_DEL_READ    = 4'd6;
    localparam logic [3:0] ACT_DEL_COMMIT  = 4'd7;
    localparam logic [3:0] ACT_UNDO_POP    = 4'd8;
    localparam logic [3:0] ACT_UNDO_LINK   = 4'd9;
    localparam logic [3:0] ACT_UNDO_RELINK = 4'd10;
    localparam logic [3:0] ACT_QUERY_READ  = 4'd11;
    localparam logic [3:0] ACT_QUERY_TAKE  = 4'd12;
    localparam logic [3:0] ACT_SET_ERR     = 4'd13;
    localparam logic [3:0] ACT_OUT_LOAD    = 4'd14;

    typedef struct packed {
        logic [3:0] act;
        logic [1:0] err;
        logic       up;
    } cld_cmd_t;

    typedef struct packed {
        logic steps_zero;
        logic link_missing;
        logic both_missing;
        logic stack_empty;
        logic sweep_last;
    } cld_status_t;

endpackage

### rtl/cld_ctrl.sv
// Sequencer for the list operations: issues datapath actions, owns the handshakes.
`timescale 1ns / 1ps

module cld_ctrl
    import cld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    output logic        out_valid,
    input  logic        out_stall,
    input  cld_status_t status,
    output cld_cmd_t    cmd
);

    localparam logic [3:0] S_RST_SWEEP   = 4'd0;
    localparam logic [3:0] S_IDLE        = 4'd1;
    localparam logic [3:0] S_MOVE_READ   = 4'd2;
    localparam logic [3:0] S_MOVE_WALK   = 4'd3;
    localparam logic [3:0] S_DEL_READ    = 4'd4;
    localparam logic [3:0] S_DEL_COMMIT  = 4'd5;
    localparam logic [3:0] S_UNDO_POP    = 4'd6;
    localparam logic [3:0] S_UNDO_LINK   = 4'd7;
    localparam logic [3:0] S_UNDO_RELINK = 4'd8;
    localparam logic [3:0] S_QUERY_READ  = 4'd9;
    localparam logic [3:0] S_QUERY_TAKE  = 4'd10;
    localparam logic [3:0] S_SWEEP_INIT  = 4'd11;
    localparam logic [3:0] S_SWEEP       = 4'd12;
    localparam logic [3:0] S_FINISH      = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd.act    = ACT_NONE;
        cmd.err    = ERR_OK;
        cmd.up     = (op_reg == OP_UP);
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_RST_SWEEP:
            begin
                cmd.act = ACT_SWEEP;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act = ACT_CAPTURE;
                    op_next = operation;
                    unique case (operation)
                        OP_UP, OP_DOWN: state_next = S_MOVE_READ;
                        OP_DELETE:      state_next = S_DEL_READ;
                        OP_UNDO:        state_next = S_UNDO_POP;
                        OP_QUERY:       state_next = S_QUERY_READ;
                        OP_REINIT:      state_next = S_SWEEP_INIT;
                        default:        state_next = S_FINISH;
                    endcase
                end
            end
            S_MOVE_READ:
            begin
                cmd.act    = ACT_MOVE_READ;
                state_next = S_MOVE_WALK;
            end
            S_MOVE_WALK:
            begin
                priority if (status.steps_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (status.link_missing)
                begin
                    cmd.act    = ACT_SET_ERR;
                    cmd.err    = ERR_END;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.act = ACT_MOVE_STEP;
                end
            end
            S_DEL_READ:
            begin
                cmd.act    = ACT_DEL_READ;
                state_next = S_DEL_COMMIT;
            end
            S_DEL_COMMIT:
            begin
                if (status.both_missing)
                begin
                    cmd.act = ACT_SET_ERR;
                    cmd.err = ERR_END;
                end
                else
                begin
                    cmd.act = ACT_DEL_COMMIT;
                end
                state_next = S_FINISH;
            end
            S_UNDO_POP:
            begin
                if (status.stack_empty)
                begin
                    cmd.act    = ACT_SET_ERR;
                    cmd.err    = ERR_EMPTY;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.act    = ACT_UNDO_POP;
                    state_next = S_UNDO_LINK;
                end
            end
            S_UNDO_LINK:
            begin
                cmd.act    = ACT_UNDO_LINK;
                state_next = S_UNDO_RELINK;
            end
            S_UNDO_RELINK:
            begin
                cmd.act    = ACT_UNDO_RELINK;
                state_next = S_FINISH;
            end
            S_QUERY_READ:
            begin
                cmd.act    = ACT_QUERY_READ;
                state_next = S_QUERY_TAKE;
            end
            S_QUERY_TAKE:
            begin
                cmd.act    = ACT_QUERY_TAKE;
                state_next = S_FINISH;
            end
            S_SWEEP_INIT:
            begin
                cmd.act    = ACT_SWEEP_INIT;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.act = ACT_SWEEP;
                if (status.sweep_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.act        = ACT_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST_SWEEP;
            op_reg        <= OP_UP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/cld_datapath.sv
// Link, flag and undo stack memories, cursor and result registers.
`timescale 1ns / 1ps

module cld_datapath
    import cld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [9:0]             step_count,
    input  logic [9:0]             row_index,
    input  cld_cmd_t               cmd,
    output cld_status_t            status,
    output logic [FIELD_ROW_W-1:0] cursor_row,
    output logic                   row_removed,
    output logic [1:0]             error_code
);

    logic [LINK_W-1:0] prev_mem [MAX_ROWS];
    logic [LINK_W-1:0] next_mem [MAX_ROWS];
    logic              removed_mem [MAX_ROWS];
    logic [ROW_W-1:0]  stack_mem [MAX_ROWS];

    logic [LINK_W-1:0] prev_rd_reg, next_rd_reg;
    logic              removed_rd_reg;
    logic [ROW_W-1:0]  stack_rd_reg;

    logic [COUNT_W-1:0]     cfg_row_count_reg;
    logic [FIELD_ROW_W-1:0] cfg_start_row_reg;

    logic [ROW_W-1:0]   cursor_reg, cursor_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [LINK_W-1:0]  n_reg, n_next;
    logic [ROW_W-1:0]   sweep_idx_reg, sweep_idx_next;

    logic [9:0]         steps_reg, steps_next;
    logic [9:0]         row_reg, row_next;
    logic [ROW_W-1:0]   undo_row_reg, undo_row_next;
    logic [1:0]         err_reg, err_next;
    logic               removed_out_reg, removed_out_next;

    logic [FIELD_ROW_W-1:0] cursor_out_reg;
    logic                   removed_o_reg;
    logic [1:0]             error_o_reg;

    // memory ports
    logic [ROW_W-1:0]  prev_raddr, next_raddr, removed_raddr, stack_raddr;
    logic              prev_we, next_we, removed_we, stack_we;
    logic [ROW_W-1:0]  prev_waddr, next_waddr, removed_waddr, stack_waddr;
    logic [LINK_W-1:0] prev_wdata, next_wdata;
    logic              removed_wdata;
    logic [ROW_W-1:0]  stack_wdata;

    logic [LINK_W-1:0] link_sel;
    logic              p_ok, nx_ok;
    logic [LINK_W-1:0] clamp_n;
    logic [ROW_W-1:0]  clamp_start;
    logic [ROW_W-1:0]  undo_row;
    logic [LINK_W-1:0] sweep_plus1;
    logic              query_ok;

    assign link_sel = cmd.up ? prev_rd_reg : next_rd_reg;
    assign p_ok     = (prev_rd_reg < NO_ROW);
    assign nx_ok    = (next_rd_reg < NO_ROW);

    assign status.steps_zero   = (steps_reg == '0);
    assign status.link_missing = (link_sel >= NO_ROW);
    assign status.both_missing = !p_ok && !nx_ok;
    assign status.stack_empty  = (depth_reg == '0);
    assign status.sweep_last   = (sweep_idx_reg == ROW_W'(MAX_ROWS - 1));

    // row count 0 counts as 1, anything above the table size as the table size
    always_comb
    begin
        priority if (cfg_row_count_reg == '0)
        begin
            clamp_n = LINK_W'(1);
        end
        else if ({1'b0, cfg_row_count_reg} > (COUNT_W + 1)'(MAX_ROWS))
        begin
            clamp_n = NO_ROW;
        end
        else
        begin
            clamp_n = LINK_W'(cfg_row_count_reg);
        end
    end

    assign clamp_start = ({1'b0, cfg_start_row_reg} < (FIELD_ROW_W + 1)'(clamp_n))
                       ? ROW_W'(cfg_start_row_reg) : ROW_W'(clamp_n - LINK_W'(1));

    assign undo_row    = (LINK_W'(stack_rd_reg) >= NO_ROW) ? '0 : stack_rd_reg;
    assign sweep_plus1 = LINK_W'(sweep_idx_reg) + LINK_W'(1);
    assign query_ok    = ({1'b0, row_reg} < 11'(MAX_ROWS));

    always_comb
    begin
        prev_raddr    = cursor_reg;
        next_raddr    = cursor_reg;
        removed_raddr = ROW_W'(row_reg);
        stack_raddr   = ROW_W'(depth_reg - DEPTH_W'(1));
        prev_we       = 1'b0;
        next_we       = 1'b0;
        removed_we    = 1'b0;
        stack_we      = 1'b0;
        prev_waddr    = sweep_idx_reg;
        next_waddr    = sweep_idx_reg;
        removed_waddr = sweep_idx_reg;
        stack_waddr   = ROW_W'(depth_reg);
        prev_wdata    = (sweep_idx_reg == '0) ? NO_ROW : LINK_W'(sweep_idx_reg) - LINK_W'(1);
        next_wdata    = (sweep_plus1 < n_reg) ? sweep_plus1 : NO_ROW;
        removed_wdata = 1'b0;
        stack_wdata   = cursor_reg;

        cursor_next      = cursor_reg;
        depth_next       = depth_reg;
        n_next           = n_reg;
        sweep_idx_next   = sweep_idx_reg;
        steps_next       = steps_reg;
        row_next         = row_reg;
        undo_row_next    = undo_row_reg;
        err_next         = err_reg;
        removed_out_next = removed_out_reg;

        unique case (cmd.act)
            ACT_CAPTURE:
            begin
                steps_next       = step_count;
                row_next         = row_index;
                err_next         = ERR_OK;
                removed_out_next = 1'b0;
            end
            ACT_SWEEP_INIT:
            begin
                n_next         = clamp_n;
                cursor_next    = clamp_start;
                depth_next     = '0;
                sweep_idx_next = '0;
            end
            ACT_SWEEP:
            begin
                prev_we        = 1'b1;
                next_we        = 1'b1;
                removed_we     = 1'b1;
                sweep_idx_next = sweep_idx_reg + ROW_W'(1);
            end
            ACT_MOVE_STEP:
            begin
                // next link read comes straight from the one just taken
                cursor_next = ROW_W'(link_sel);
                prev_raddr  = ROW_W'(link_sel);
                next_raddr  = ROW_W'(link_sel);
                steps_next  = steps_reg - 10'd1;
            end
            ACT_DEL_COMMIT:
            begin
                removed_we    = 1'b1;
                removed_waddr = cursor_reg;
                removed_wdata = 1'b1;
                if (depth_reg < DEPTH_W'(MAX_ROWS))
                begin
                    stack_we   = 1'b1;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                next_we    = p_ok;
                next_waddr = ROW_W'(prev_rd_reg);
                next_wdata = next_rd_reg;
                prev_we    = nx_ok;
                prev_waddr = ROW_W'(next_rd_reg);
                prev_wdata = prev_rd_reg;
                cursor_next = nx_ok ? ROW_W'(next_rd_reg) : ROW_W'(prev_rd_reg);
            end
            ACT_UNDO_POP:
            begin
                depth_next = depth_reg - DEPTH_W'(1);
            end
            ACT_UNDO_LINK:
            begin
                undo_row_next = undo_row;
                removed_we    = 1'b1;
                removed_waddr = undo_row;
                removed_wdata = 1'b0;
                prev_raddr    = undo_row;
                next_raddr    = undo_row;
            end
            ACT_UNDO_RELINK:
            begin
                next_we    = p_ok;
                next_waddr = ROW_W'(prev_rd_reg);
                next_wdata = LINK_W'(undo_row_reg);
                prev_we    = nx_ok;
                prev_waddr = ROW_W'(next_rd_reg);
                prev_wdata = LINK_W'(undo_row_reg);
            end
            ACT_QUERY_TAKE:
            begin
                removed_out_next = query_ok && removed_rd_reg;
            end
            ACT_SET_ERR:
            begin
                err_next = cmd.err;
            end
            default:
            begin
                // no-op, move read, delete read, query read and output load
                // use the default addresses or touch only the output registers
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (removed_we)
        begin
            removed_mem[removed_waddr] <= removed_wdata;
        end
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        prev_rd_reg    <= prev_mem[prev_raddr];
        next_rd_reg    <= next_mem[next_raddr];
        removed_rd_reg <= removed_mem[removed_raddr];
        stack_rd_reg   <= stack_mem[stack_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_row_count_reg <= COUNT_W'(RESET_ROW_COUNT);
            cfg_start_row_reg <= '0;
            cursor_reg        <= '0;
            depth_reg         <= '0;
            n_reg             <= LINK_W'(RESET_N);
            sweep_idx_reg     <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == CFG_ROW_COUNT))
            begin
                cfg_row_count_reg <= COUNT_W'(cfg_data);
            end
            if (cfg_write && (cfg_index == CFG_START_ROW))
            begin
                cfg_start_row_reg <= FIELD_ROW_W'(cfg_data);
            end
            cursor_reg    <= cursor_next;
            depth_reg     <= depth_next;
            n_reg         <= n_next;
            sweep_idx_reg <= sweep_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg       <= steps_next;
        row_reg         <= row_next;
        undo_row_reg    <= undo_row_next;
        err_reg         <= err_next;
        removed_out_reg <= removed_out_next;
        if (cmd.act == ACT_OUT_LOAD)
        begin
            cursor_out_reg <= FIELD_ROW_W'(cursor_reg);
            removed_o_reg  <= removed_out_reg;
            error_o_reg    <= err_reg;
        end
    end

    assign cursor_row  = cursor_out_reg;
    assign row_removed = removed_o_reg;
    assign error_code  = error_o_reg;

endmodule

### rtl/cursor_list_delete_undo.sv
// Top level: linked-list row table with cursor, delete and undo.
// Operation steps: move reads, walks; delete reads, commits; undo pops, links, relinks (or
// flags an empty stack); query reads, takes; reinit writes one link-memory row per cycle.
// One item at a time; the next transfer is taken the cycle after the result is registered,
// and a result waits while a previous one is stalled. Moves walk one link per cycle. Reset
// is asynchronous, active low; after it a clearing pass over all MAX_ROWS (1024) rows
// rebuilds the chain with in_stall high. Register writes are taken throughout.
`timescale 1ns / 1ps

module cursor_list_delete_undo
    import cld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             operation,
    input  logic [9:0]             step_count,
    input  logic [9:0]             row_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FIELD_ROW_W-1:0] cursor_row,
    output logic                   row_removed,
    output logic [1:0]             error_code
);

    cld_cmd_t    cmd;
    cld_status_t status;

    cld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cld_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step_count  (step_count),
        .row_index   (row_index),
        .cmd         (cmd),
        .status      (status),
        .cursor_row  (cursor_row),
        .row_removed (row_removed),
        .error_code  (error_code)
    );

endmodule
